// ===== hdl/blmc_pkg.sv =====
// shared types, constants and step helpers for the button mode led controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package blmc_pkg;

  localparam int unsigned TICKS_PER_UNIT = 10;

  localparam int unsigned TICK_W     = 16;
  localparam int unsigned TIME_W     = 13;
  localparam int unsigned TRIM_W     = 12;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned GAP_W      = 2;

  // width of an on-time or off-time threshold in ticks
  localparam int unsigned THR_W = $clog2(((1 << TIME_W) - 1) * TICKS_PER_UNIT + 1);
  localparam int unsigned CMP_W = (THR_W > TICK_W) ? THR_W : TICK_W;

  // trimmer pulse gap: gap = ((level*100/255)*255)/10000, level = sample/16
  // gap >= 1 once duty >= ceil(10000/255), reached at level >= ceil(duty*255/100)
  localparam int unsigned GAP1_DUTY  = (10000 + 254) / 255;
  localparam int unsigned GAP2_DUTY  = (20000 + 254) / 255;
  localparam int unsigned GAP1_LEVEL = (GAP1_DUTY * 255 + 99) / 100;
  localparam int unsigned GAP2_LEVEL = (GAP2_DUTY * 255 + 99) / 100;

  localparam logic [TICK_W-1:0] STARTUP_DELAY_RST = TICK_W'(10000);
  localparam logic [TIME_W-1:0] TEST1_ON_RST     = TIME_W'(300);
  localparam logic [TIME_W-1:0] TEST2_ON_RST     = TIME_W'(800);
  localparam logic [TIME_W-1:0] ERROR_ON_RST     = TIME_W'(500);
  localparam logic [TIME_W-1:0] BLINK_PERIOD_RST = TIME_W'(1000);
  localparam logic [TRIM_W-1:0] TRIM_LOW_RST     = TRIM_W'(50);
  localparam logic [TRIM_W-1:0] TRIM_HIGH_RST    = TRIM_W'(3950);

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT    = 3'd0,
    MODE_STARTUP = 3'd1,
    MODE_RUN     = 3'd2,
    MODE_TEST1   = 3'd3,
    MODE_TEST2   = 3'd4,
    MODE_ERROR   = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STARTUP_DELAY = 3'd0,
    REG_TEST1_ON_TIME = 3'd1,
    REG_TEST2_ON_TIME = 3'd2,
    REG_ERROR_ON_TIME = 3'd3,
    REG_BLINK_PERIOD  = 3'd4,
    REG_TRIM_LOW      = 3'd5,
    REG_TRIM_HIGH     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic              button_one;
    logic              button_two;
    logic [TRIM_W-1:0] trimmer_sample;
  } in_item_t;

  typedef struct packed {
    logic              blue_on;
    logic              red_on;
    logic [MODE_W-1:0] mode_now;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] startup_delay;
    logic [TIME_W-1:0] test1_on_time;
    logic [TIME_W-1:0] test2_on_time;
    logic [TIME_W-1:0] error_on_time;
    logic [TIME_W-1:0] blink_period;
    logic [TRIM_W-1:0] trim_low;
    logic [TRIM_W-1:0] trim_high;
  } cfg_t;

  typedef struct packed {
    logic              lit;
    logic [TICK_W-1:0] on_mark;
    logic [TICK_W-1:0] off_mark;
  } blink_t;

  // one blink update of a led and its two marks
  function automatic blink_t blink_step(blink_t cur, logic [TIME_W-1:0] on_time,
                                        logic [TIME_W-1:0] period,
                                        logic [TICK_W-1:0] tick);
    blink_t            r;
    logic [CMP_W-1:0]  on_thr;
    logic [CMP_W-1:0]  off_thr;
    logic [TICK_W-1:0] on_el;
    logic [TICK_W-1:0] off_el;
    r       = cur;
    on_thr  = CMP_W'(on_time * TICKS_PER_UNIT);
    off_thr = CMP_W'((period - on_time) * TICKS_PER_UNIT);
    if (period == '0) begin
      r.lit = 1'b0;
    end else if (on_time >= period) begin
      r.lit = 1'b1;
    end else begin
      on_el = tick - r.on_mark;
      if (r.lit && (CMP_W'(on_el) >= on_thr)) begin
        r.on_mark  = '0;
        r.lit      = 1'b0;
        r.off_mark = tick;
      end
      off_el = tick - r.off_mark;
      if (!r.lit && (CMP_W'(off_el) >= off_thr)) begin
        r.off_mark = '0;
        r.lit      = 1'b1;
        r.on_mark  = tick;
      end
    end
    return r;
  endfunction

  function automatic logic [GAP_W-1:0] trim_gap(logic [LEVEL_W-1:0] level);
    logic [GAP_W-1:0] g;
    if (32'(level) >= GAP2_LEVEL) begin
      g = GAP_W'(2);
    end else if (32'(level) >= GAP1_LEVEL) begin
      g = GAP_W'(1);
    end else begin
      g = '0;
    end
    return g;
  endfunction

endpackage

// ===== hdl/blmc_cfg.sv =====
// configuration register file: seven timing and threshold registers
// depends on blmc_pkg
`timescale 1ns / 1ps

module blmc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [blmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blmc_pkg::CFG_DATA_W-1:0] cfg_data,
  output blmc_pkg::cfg_t                 cfg
);
  import blmc_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.startup_delay <= STARTUP_DELAY_RST;
      regs.test1_on_time <= TEST1_ON_RST;
      regs.test2_on_time <= TEST2_ON_RST;
      regs.error_on_time <= ERROR_ON_RST;
      regs.blink_period  <= BLINK_PERIOD_RST;
      regs.trim_low      <= TRIM_LOW_RST;
      regs.trim_high     <= TRIM_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STARTUP_DELAY: regs.startup_delay <= cfg_data[TICK_W-1:0];
        REG_TEST1_ON_TIME: regs.test1_on_time <= cfg_data[TIME_W-1:0];
        REG_TEST2_ON_TIME: regs.test2_on_time <= cfg_data[TIME_W-1:0];
        REG_ERROR_ON_TIME: regs.error_on_time <= cfg_data[TIME_W-1:0];
        REG_BLINK_PERIOD:  regs.blink_period  <= cfg_data[TIME_W-1:0];
        REG_TRIM_LOW:      regs.trim_low      <= cfg_data[TRIM_W-1:0];
        REG_TRIM_HIGH:     regs.trim_high     <= cfg_data[TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hdl/blmc_step.sv =====
// mode sequencer state and one-tick update logic
// depends on blmc_pkg
`timescale 1ns / 1ps

module blmc_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  blmc_pkg::in_item_t  item,
  input  blmc_pkg::cfg_t      cfg,
  output blmc_pkg::out_item_t result
);
  import blmc_pkg::*;

  mode_t             mode, mode_next;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] startup_mark, startup_mark_next;
  logic [TICK_W-1:0] trimmer_mark, trimmer_mark_next;
  blink_t            blue, blue_next;
  blink_t            red, red_next;

  logic              b1, b2;
  logic [TICK_W-1:0] startup_el;
  logic [TICK_W-1:0] trim_el;
  logic [TIME_W-1:0] test_on_time;
  blink_t            blue_blink;
  blink_t            red_blink;
  logic [GAP_W-1:0]  gap;
  logic              trim_fire;

  assign b1           = item.button_one;
  assign b2           = item.button_two;
  assign startup_el   = tick_count - startup_mark;
  assign trim_el      = tick_count - trimmer_mark;
  assign test_on_time = (mode == MODE_TEST1) ? cfg.test1_on_time : cfg.test2_on_time;
  assign blue_blink   = blink_step(blue, test_on_time, cfg.blink_period, tick_count);
  assign red_blink    = blink_step(red, cfg.error_on_time, cfg.blink_period, tick_count);
  assign gap          = trim_gap(item.trimmer_sample[TRIM_W-1 -: LEVEL_W]);
  assign trim_fire    = (trim_el >= TICK_W'(gap));

  // next mode
  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_INIT: begin
        if (b1 && !b2) mode_next = MODE_STARTUP;
      end
      MODE_STARTUP: begin
        if (!b1 && !b2) begin
          mode_next = MODE_INIT;
        end else if (startup_el >= cfg.startup_delay) begin
          mode_next = MODE_RUN;
        end
      end
      MODE_RUN: begin
        if (b2) mode_next = b1 ? MODE_TEST2 : MODE_TEST1;
      end
      MODE_TEST1, MODE_TEST2: begin
        if (!b2) mode_next = MODE_ERROR;
      end
      MODE_ERROR: begin
        if (!b1 && !b2) mode_next = MODE_INIT;
      end
      default: ;
    endcase
  end

  // leds and marks
  always_comb begin
    blue_next         = blue;
    red_next          = red;
    startup_mark_next = startup_mark;
    trimmer_mark_next = trimmer_mark;
    unique case (mode)
      MODE_INIT: begin
        if (!b1 && !b2) begin
          blue_next.lit     = 1'b0;
          red_next.lit      = 1'b1;
          startup_mark_next = '0;
        end else if (b1 && !b2) begin
          startup_mark_next = tick_count;
        end
      end
      MODE_STARTUP: begin
        if (b1 || b2) begin
          blue_next.lit = 1'b1;
          red_next.lit  = 1'b1;
        end
      end
      MODE_RUN: begin
        blue_next.lit = 1'b1;
        red_next.lit  = 1'b0;
      end
      MODE_TEST1, MODE_TEST2: begin
        blue_next = blue_blink;
        priority if (item.trimmer_sample < cfg.trim_low) begin
          red_next.lit = 1'b1;
        end else if (item.trimmer_sample > cfg.trim_high) begin
          red_next.lit = 1'b0;
        end else begin
          red_next.lit = trim_fire;
          if (trim_fire) trimmer_mark_next = tick_count;
        end
      end
      MODE_ERROR: begin
        blue_next.lit = 1'b0;
        red_next      = red_blink;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_INIT;
      tick_count   <= '0;
      startup_mark <= '0;
      trimmer_mark <= '0;
      blue         <= '0;
      red          <= '0;
    end else if (advance) begin
      mode         <= mode_next;
      tick_count   <= tick_count + TICK_W'(1);
      startup_mark <= startup_mark_next;
      trimmer_mark <= trimmer_mark_next;
      blue         <= blue_next;
      red          <= red_next;
    end
  end

  assign result.blue_on  = blue_next.lit;
  assign result.red_on   = red_next.lit;
  assign result.mode_now = mode_next;

  a_tick_steps: assert property (@(posedge clk) disable iff (rst)
    advance |=> tick_count == $past(tick_count) + TICK_W'(1))
    else $error("tick count did not step with an item");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(tick_count) && $stable(mode) && $stable(blue) && $stable(red))
    else $error("state changed without an item");

  a_error_blue_dark: assert property (@(posedge clk) disable iff (rst)
    (advance && mode == MODE_ERROR) |=> !blue.lit)
    else $error("blue lit after an error-mode item");

  a_run_leds: assert property (@(posedge clk) disable iff (rst)
    (advance && mode == MODE_RUN) |=> blue.lit && !red.lit)
    else $error("run mode leds wrong");

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_INIT || mode == MODE_STARTUP || mode == MODE_RUN ||
    mode == MODE_TEST1 || mode == MODE_TEST2 || mode == MODE_ERROR)
    else $error("mode left the six defined codes");

endmodule

// ===== hdl/button_mode_led_controller.sv =====
// button mode led controller top level: input register, sequencer, result register
// depends on blmc_pkg, blmc_cfg, blmc_step
//
// usage:
//   in_item carries one 100 us tick: two button flags and a 12-bit trimmer
//   sample. out_item returns the blue and red led states and the mode after
//   that tick, exactly one item out for every item in.
//   both channels are valid/stall: an item moves on a rising edge with valid
//   high and stall low.
//   an accepted item is held in the input register; when it moves on, the
//   sequencer update writes the result register and out_valid rises with it.
//   throughput is one item per cycle while the receiver does not stall.
//   when the receiver stalls, the result register holds and the input register
//   keeps its item; in_stall rises only once both are full.
//   reset (rst, synchronous, active high) returns the sequencer to init, clears
//   the tick counter, marks and leds, empties both registers and loads the
//   configuration registers with their defaults. cfg_wr_en/cfg_index/cfg_data
//   write one register per cycle; user must write only while idle (not enforced).
`timescale 1ns / 1ps

module button_mode_led_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  blmc_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output blmc_pkg::out_item_t             out_item,
  input  logic                            cfg_wr_en,
  input  logic [blmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blmc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import blmc_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  logic      item_valid;
  logic      advance;
  out_item_t result;
  out_item_t result_q;
  logic      result_valid;

  // item moves from input register to result register
  assign advance  = item_valid && (!result_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  blmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  blmc_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!out_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_valid = result_valid;
  assign out_item  = result_q;

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("result register empty after an item moved");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && result_valid && out_stall)
    else $error("input stalled with room downstream");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_stall) |=> result_valid && $stable(result_q))
    else $error("stalled result lost or changed");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for button_mode_led_controller: walks the six-mode
// led sequencer with directed and random tick items and checks every result
// item against a cycle-free model of the sequencer; depends on blmc_pkg
`timescale 1ns / 1ps

module testbench;
  import blmc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // sequencer model state and register shadow
  cfg_t              regs;
  mode_t             seq_mode;
  logic [TICK_W-1:0] ticks;
  logic [TICK_W-1:0] start_mark;
  logic              blue_lit;
  logic              red_lit;
  logic [TICK_W-1:0] blue_on_at;
  logic [TICK_W-1:0] blue_off_at;
  logic [TICK_W-1:0] red_on_at;
  logic [TICK_W-1:0] red_off_at;
  logic [TICK_W-1:0] pulse_mark;

  out_item_t   expected_leds[$];
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned settings_used   = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned send_idle_pct   = 34;
  int unsigned recv_idle_pct   = 71;
  logic [5:0]  modes_reached   = '0;

  button_mode_led_controller dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic reset_sequencer_model();
    regs.startup_delay = STARTUP_DELAY_RST;
    regs.test1_on_time = TEST1_ON_RST;
    regs.test2_on_time = TEST2_ON_RST;
    regs.error_on_time = ERROR_ON_RST;
    regs.blink_period  = BLINK_PERIOD_RST;
    regs.trim_low      = TRIM_LOW_RST;
    regs.trim_high     = TRIM_HIGH_RST;
    seq_mode    = MODE_INIT;
    ticks       = '0;
    start_mark  = '0;
    blue_lit    = 1'b0;
    red_lit     = 1'b0;
    blue_on_at  = '0;
    blue_off_at = '0;
    red_on_at   = '0;
    red_off_at  = '0;
    pulse_mark  = '0;
  endtask

  task automatic blink_led(inout logic lit, inout logic [TICK_W-1:0] on_at,
                           inout logic [TICK_W-1:0] off_at,
                           input logic [TIME_W-1:0] on_units);
    int unsigned       on_thr;
    int unsigned       off_thr;
    logic [TICK_W-1:0] el;
    if (regs.blink_period == '0) begin
      lit = 1'b0;
    end else if (on_units >= regs.blink_period) begin
      lit = 1'b1;
    end else begin
      // thresholds kept at 32 bits, so anything above 65535 never fires
      on_thr  = 32'(on_units) * TICKS_PER_UNIT;
      off_thr = (32'(regs.blink_period) - 32'(on_units)) * TICKS_PER_UNIT;
      el = ticks - on_at;
      if (lit && 32'(el) >= on_thr) begin
        on_at  = '0;
        lit    = 1'b0;
        off_at = ticks;
      end
      el = ticks - off_at;
      if (!lit && 32'(el) >= off_thr) begin
        off_at = '0;
        lit    = 1'b1;
        on_at  = ticks;
      end
    end
  endtask

  task automatic drive_red_from_trimmer(input logic [TRIM_W-1:0] s);
    int unsigned       level;
    int unsigned       duty;
    int unsigned       gap;
    logic [TICK_W-1:0] el;
    if (s < regs.trim_low) begin
      red_lit = 1'b1;
    end else if (s > regs.trim_high) begin
      red_lit = 1'b0;
    end else begin
      level = 32'(s) / 16;
      duty  = (level * 100) / 255;
      gap   = (duty * 255) / 10000;
      el    = ticks - pulse_mark;
      if (32'(el) >= gap) begin
        red_lit    = 1'b1;
        pulse_mark = ticks;
      end else begin
        red_lit = 1'b0;
      end
    end
  endtask

  // one tick of the sequencer; returns the led states and mode after it
  task automatic advance_sequencer(input in_item_t it, output out_item_t res);
    logic              b1;
    logic              b2;
    logic [TICK_W-1:0] el;
    b1 = it.button_one;
    b2 = it.button_two;
    case (seq_mode)
      MODE_INIT: begin
        if (!b1 && !b2) begin
          blue_lit   = 1'b0;
          red_lit    = 1'b1;
          start_mark = '0;
        end
        if (b1 && !b2) begin
          seq_mode   = MODE_STARTUP;
          start_mark = ticks;
        end
      end
      MODE_STARTUP: begin
        if (!b1 && !b2) begin
          seq_mode = MODE_INIT;
        end else begin
          blue_lit = 1'b1;
          red_lit  = 1'b1;
          el = ticks - start_mark;
          if (el >= regs.startup_delay) seq_mode = MODE_RUN;
        end
      end
      MODE_RUN: begin
        blue_lit = 1'b1;
        red_lit  = 1'b0;
        if (!b1 && b2) seq_mode = MODE_TEST1;
        if (b1 && b2) seq_mode = MODE_TEST2;
      end
      MODE_TEST1, MODE_TEST2: begin
        blink_led(blue_lit, blue_on_at, blue_off_at,
                  (seq_mode == MODE_TEST1) ? regs.test1_on_time : regs.test2_on_time);
        drive_red_from_trimmer(it.trimmer_sample);
        if (!b2) seq_mode = MODE_ERROR;
      end
      MODE_ERROR: begin
        blue_lit = 1'b0;
        blink_led(red_lit, red_on_at, red_off_at, regs.error_on_time);
        if (!b1 && !b2) seq_mode = MODE_INIT;
      end
      default: begin
      end
    endcase
    ticks = ticks + 1'b1;
    modes_reached[seq_mode] = 1'b1;
    res.blue_on  = blue_lit;
    res.red_on   = red_lit;
    res.mode_now = seq_mode;
  endtask

  task automatic send_item(input logic b1, input logic b2, input logic [TRIM_W-1:0] s);
    in_item_t  it;
    out_item_t res;
    it.button_one     = b1;
    it.button_two     = b2;
    it.trimmer_sample = s;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sequencer(it, res);
    expected_leds.push_back(res);
    items_sent++;
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_STARTUP_DELAY: regs.startup_delay = val;
      REG_TEST1_ON_TIME: regs.test1_on_time = val[TIME_W-1:0];
      REG_TEST2_ON_TIME: regs.test2_on_time = val[TIME_W-1:0];
      REG_ERROR_ON_TIME: regs.error_on_time = val[TIME_W-1:0];
      REG_BLINK_PERIOD:  regs.blink_period  = val[TIME_W-1:0];
      REG_TRIM_LOW:      regs.trim_low      = val[TRIM_W-1:0];
      REG_TRIM_HIGH:     regs.trim_high     = val[TRIM_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic go_to_init();
    while (seq_mode != MODE_INIT) begin
      if (seq_mode == MODE_RUN) begin
        send_item(1'b0, 1'b1, TRIM_W'($urandom_range(0, 4095)));
      end else begin
        send_item(1'b0, 1'b0, TRIM_W'($urandom_range(0, 4095)));
      end
    end
  endtask

  // {button_one, button_two}, mostly steering deeper into the mode sequence
  function automatic logic [1:0] pick_buttons();
    logic [1:0]  b;
    int unsigned r;
    r = $urandom_range(0, 99);
    b = 2'($urandom_range(0, 3));
    case (seq_mode)
      MODE_INIT:    if (r < 60) b = 2'b10;
      MODE_STARTUP: if (r < 90 && b == 2'b00) b = 2'($urandom_range(1, 3));
      MODE_RUN:     if (r < 70) b = {1'($urandom_range(0, 1)), 1'b1};
      MODE_TEST1, MODE_TEST2: if (r < 96) b[0] = 1'b1;
      MODE_ERROR:   if (r < 92 && b == 2'b00) b = 2'($urandom_range(1, 3));
      default: begin
      end
    endcase
    return b;
  endfunction

  function automatic logic [TRIM_W-1:0] pick_sample();
    logic [TRIM_W-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: s = TRIM_W'($urandom_range(0, 4095));
      5, 6:          s = regs.trim_low + TRIM_W'($urandom_range(0, 2)) - 1'b1;
      7, 8:          s = regs.trim_high + TRIM_W'($urandom_range(0, 2)) - 1'b1;
      default:       s = ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
    return s;
  endfunction

  task automatic pick_random_settings();
    int unsigned       period;
    logic [TRIM_W-1:0] lo;
    logic [TRIM_W-1:0] hi;
    period = $urandom_range(0, 5);
    lo     = TRIM_W'($urandom_range(0, 1500));
    hi     = TRIM_W'($urandom_range(2500, 4095));
    write_setting(REG_STARTUP_DELAY, CFG_DATA_W'($urandom_range(0, 20)));
    write_setting(REG_BLINK_PERIOD, CFG_DATA_W'(period));
    write_setting(REG_TEST1_ON_TIME, CFG_DATA_W'($urandom_range(0, period + 1)));
    write_setting(REG_TEST2_ON_TIME, CFG_DATA_W'($urandom_range(0, period + 1)));
    write_setting(REG_ERROR_ON_TIME, CFG_DATA_W'($urandom_range(0, period + 1)));
    if ($urandom_range(0, 4) == 0) begin
      // inverted window
      write_setting(REG_TRIM_LOW, CFG_DATA_W'(hi));
      write_setting(REG_TRIM_HIGH, CFG_DATA_W'(lo));
    end else begin
      write_setting(REG_TRIM_LOW, CFG_DATA_W'(lo));
      write_setting(REG_TRIM_HIGH, CFG_DATA_W'(hi));
    end
    settings_used++;
  endtask

  task automatic test_directed_walk();
    wait_idle();
    write_setting(REG_STARTUP_DELAY, 16'd3);
    write_setting(REG_TEST1_ON_TIME, 16'd1);
    write_setting(REG_TEST2_ON_TIME, 16'd3);
    write_setting(REG_ERROR_ON_TIME, 16'd2);
    write_setting(REG_BLINK_PERIOD, 16'd4);
    write_setting(REG_TRIM_LOW, 16'd100);
    write_setting(REG_TRIM_HIGH, 16'd3000);
    settings_used++;
    // init: idle combo, then combos without an action
    send_item(1'b0, 1'b0, 12'h000);
    send_item(1'b1, 1'b1, 12'hFFF);
    send_item(1'b0, 1'b1, 12'hAAA);
    // start-up, abort back to init, start-up again through to run
    send_item(1'b1, 1'b0, 12'h555);
    send_item(1'b0, 1'b0, 12'h000);
    send_item(1'b1, 1'b0, 12'h000);
    send_item(1'b1, 1'b1, 12'h000);
    send_item(1'b0, 1'b1, 12'h000);
    send_item(1'b1, 1'b0, 12'h000);
    send_item(1'b1, 1'b0, 12'h000);
    send_item(1'b0, 1'b1, 12'h000);
    // test1: below low, above high, pulse gaps of one and two, window edges
    send_item(1'b1, 1'b1, 12'd99);
    send_item(1'b0, 1'b1, 12'd3001);
    send_item(1'b1, 1'b1, 12'd1632);
    send_item(1'b1, 1'b1, 12'd3264);
    send_item(1'b0, 1'b1, 12'd100);
    send_item(1'b0, 1'b1, 12'd3000);
    // error and back to init
    send_item(1'b1, 1'b0, 12'h000);
    send_item(1'b1, 1'b1, 12'h000);
    send_item(1'b1, 1'b1, 12'h000);
    send_item(1'b0, 1'b1, 12'h000);
    send_item(1'b0, 1'b0, 12'h000);
  endtask

  task automatic test_setting_extremes();
    wait_idle();
    // zero period forces leds off, instant start, inverted trimmer window
    write_setting(REG_STARTUP_DELAY, 16'd0);
    write_setting(REG_BLINK_PERIOD, 16'd0);
    write_setting(REG_TEST2_ON_TIME, 16'd8191);
    write_setting(REG_TRIM_LOW, 16'd4095);
    write_setting(REG_TRIM_HIGH, 16'd0);
    settings_used++;
    go_to_init();
    send_item(1'b1, 1'b0, 12'd0);
    send_item(1'b1, 1'b1, 12'd0);
    send_item(1'b1, 1'b1, 12'd4094);
    send_item(1'b1, 1'b1, 12'd4095);
    send_item(1'b1, 1'b0, 12'd0);
    send_item(1'b0, 1'b0, 12'd0);
    wait_idle();
    // thresholds past the 16-bit tick range hold the led where it is
    write_setting(REG_BLINK_PERIOD, 16'd8191);
    write_setting(REG_TEST1_ON_TIME, 16'd0);
    write_setting(REG_ERROR_ON_TIME, 16'd8190);
    write_setting(REG_TRIM_LOW, 16'd0);
    write_setting(REG_TRIM_HIGH, 16'd4095);
    settings_used++;
    send_item(1'b1, 1'b0, 12'd0);
    send_item(1'b0, 1'b1, 12'd0);
    send_item(1'b0, 1'b1, 12'd0);
    send_item(1'b0, 1'b1, 12'd2048);
    send_item(1'b0, 1'b0, 12'd2048);
    repeat (12) send_item(1'b1, 1'b0, 12'd0);
    send_item(1'b0, 1'b0, 12'd0);
  endtask

  // longest start-up delay; the sequencer stays in start-up throughout
  task automatic test_startup_wrap();
    logic [1:0] b;
    go_to_init();
    wait_idle();
    write_setting(REG_STARTUP_DELAY, 16'hFFFF);
    settings_used++;
    send_item(1'b1, 1'b0, TRIM_W'($urandom_range(0, 4095)));
    for (int i = 0; i < 150; i++) begin
      b = 2'($urandom_range(1, 3));
      send_item(b[1], b[0], TRIM_W'($urandom_range(0, 4095)));
    end
  endtask

  task automatic test_random_phase(input int unsigned n);
    logic [1:0] b;
    wait_idle();
    pick_random_settings();
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) == 0) wait_idle();
      b = pick_buttons();
      send_item(b[1], b[0], pick_sample());
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_leds.size() == 0) begin
          $error("result item with nothing expected: %p", out_item);
          mismatches = mismatches + 1;
        end else begin
          want = expected_leds.pop_front();
          results_checked = results_checked + 1;
          if (out_item.blue_on !== want.blue_on) begin
            $error("blue_on: expected %0b, got %0b", want.blue_on, out_item.blue_on);
            mismatches = mismatches + 1;
          end
          if (out_item.red_on !== want.red_on) begin
            $error("red_on: expected %0b, got %0b", want.red_on, out_item.red_on);
            mismatches = mismatches + 1;
          end
          if (out_item.mode_now !== want.mode_now) begin
            $error("mode_now: expected %0d, got %0d", want.mode_now, out_item.mode_now);
            mismatches = mismatches + 1;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_sequencer_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_walk();
    test_setting_extremes();
    for (int p = 0; p < 4; p++) begin
      if (p == 2) begin
        send_idle_pct = 71;
        recv_idle_pct = 34;
      end
      test_random_phase(160);
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_startup_wrap();
    test_random_phase(160);
    test_random_phase(160);
    wait_idle();
    repeat (8) @(posedge clk);
    $display("sent %0d items under %0d register settings, checked %0d results",
             items_sent, settings_used, results_checked);
    $display("modes reached, error down to init: %b", modes_reached);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
